// File: sv/sha256_pkg.sv
package sha256_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_INIT,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } state_t;

    localparam int BlockLen = 64;
    localparam int LenPos   = 56;
    localparam logic [7:0] PadMark = 8'h80;

    localparam logic [31:0] InitHash [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        ror32 = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// File: sv/sha256_stream_hash_top.sv
// sha-256 over a byte stream, at most one byte per input transfer
// a byte that fills the block adds a compression: block load, rounds and fold
// on the single round unit
// a last item adds a pad sweep, one or two compressions and
// 8 digest word transfers; in_stall is high throughout
// rst_n clears control state and reloads the initial hash values
module sha256_stream_hash_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);
    import sha256_pkg::*;

    state_t state_reg, state_next;

    logic [7:0]  blk_mem [BlockLen];
    logic [31:0] hash_reg [8];
    logic [31:0] wk_reg [8];
    logic [31:0] sched_reg [16];
    logic [5:0]  fill_reg;
    logic [63:0] len_reg;
    logic [6:0]  rnd_reg;
    logic [1:0]  bsel_reg;
    logic [31:0] wload_reg;
    logic        fin_reg;
    logic        two_reg;
    logic        mark_reg;
    logic [2:0]  widx_reg;
    logic [7:0]  rd_reg;

    logic        in_xfer, out_xfer;
    logic [5:0]  wr_addr;
    logic [7:0]  wr_data;
    logic        wr_en;
    logic [5:0]  rd_addr;

    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid && !out_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_EMIT);
    assign digest_word = hash_reg[widx_reg];
    assign word_index  = widx_reg;
    assign last_word   = (widx_reg == 3'd7);

    // pad byte for the current sweep position
    logic [7:0] pad_byte;
    always_comb
    begin
        if (fill_reg >= 6'(LenPos) && !two_reg)
            pad_byte = len_reg[6'(63 - 8 * 32'(fill_reg - 6'(LenPos))) -: 8];
        else
            pad_byte = 8'h00;
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = fill_reg;
        wr_data = data_byte;
        if (state_reg == ST_IDLE && in_xfer)
        begin
            if (byte_valid)
            begin
                wr_en = 1'b1;
            end
        end
        else if (state_reg == ST_PAD)
        begin
            wr_en = 1'b1;
            wr_data = mark_reg ? PadMark : pad_byte;
        end
    end

    // load reads bytes in order; rnd holds word, bsel the byte
    assign rd_addr = {rnd_reg[3:0], bsel_reg};

    always_ff @(posedge clk)
    begin
        if (wr_en)
            blk_mem[wr_addr] <= wr_data;
        rd_reg <= blk_mem[rd_addr];
    end

    // round unit
    logic [31:0] w_cur, s0, s1, t1, t2, big0, big1, chs, maj, w15, w2;
    always_comb
    begin
        w15 = sched_reg[4'(rnd_reg[3:0] + 4'd1)];
        w2  = sched_reg[4'(rnd_reg[3:0] + 4'd14)];
        s0  = ror32(w15, 7) ^ ror32(w15, 18) ^ (w15 >> 3);
        s1  = ror32(w2, 17) ^ ror32(w2, 19) ^ (w2 >> 10);
        if (rnd_reg < 7'd16)
            w_cur = sched_reg[rnd_reg[3:0]];
        else
            w_cur = sched_reg[rnd_reg[3:0]] + s0
                    + sched_reg[4'(rnd_reg[3:0] + 4'd9)] + s1;
        big1 = ror32(wk_reg[4], 6) ^ ror32(wk_reg[4], 11) ^ ror32(wk_reg[4], 25);
        chs  = (wk_reg[4] & wk_reg[5]) ^ (~wk_reg[4] & wk_reg[6]);
        t1   = wk_reg[7] + big1 + chs + RoundK[rnd_reg[5:0]] + w_cur;
        big0 = ror32(wk_reg[0], 2) ^ ror32(wk_reg[0], 13) ^ ror32(wk_reg[0], 22);
        maj  = (wk_reg[0] & wk_reg[1]) ^ (wk_reg[0] & wk_reg[2])
               ^ (wk_reg[1] & wk_reg[2]);
        t2   = big0 + maj;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (byte_valid && fill_reg == 6'd63)
                        state_next = ST_INIT;
                    else if (last_byte)
                        state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                if (fill_reg == 6'd63)
                    state_next = ST_INIT;
            end
            ST_INIT:
            begin
                if (rnd_reg == 7'd15 && bsel_reg == 2'd3)
                    state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (rnd_reg == 7'd63)
                    state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                if (mark_reg || two_reg)
                    state_next = ST_PAD;
                else if (fin_reg)
                    state_next = ST_EMIT;
                else
                    state_next = ST_IDLE;
            end
            ST_EMIT:
            begin
                if (out_xfer && widx_reg == 3'd7)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            for (int i = 0; i < 8; i++)
                hash_reg[i] <= InitHash[i];
            fill_reg <= '0;
            len_reg  <= '0;
            rnd_reg  <= '0;
            bsel_reg <= '0;
            fin_reg  <= 1'b0;
            two_reg  <= 1'b0;
            mark_reg <= 1'b0;
            widx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                begin
                    rnd_reg  <= '0;
                    bsel_reg <= '0;
                    if (in_xfer)
                    begin
                        fin_reg  <= last_byte;
                        mark_reg <= last_byte;
                        if (byte_valid)
                        begin
                            len_reg  <= len_reg + 64'd8;
                            fill_reg <= fill_reg + 6'd1;
                        end
                    end
                end
                ST_PAD:
                begin
                    fill_reg <= fill_reg + 6'd1;
                    rnd_reg  <= '0;
                    bsel_reg <= '0;
                    // the pad mark goes first; no room for the length means an extra block
                    if (mark_reg)
                    begin
                        mark_reg <= 1'b0;
                        two_reg  <= (fill_reg > 6'd55);
                    end
                end
                ST_INIT:
                begin
                    // registered read: bsel steps, data lands next
                    bsel_reg <= bsel_reg + 2'd1;
                    wload_reg <= {wload_reg[23:0], rd_reg};
                    if (bsel_reg == 2'd0 && rnd_reg != 7'd0)
                        sched_reg[4'(rnd_reg[3:0] - 4'd1)] <= {wload_reg[23:0], rd_reg};
                    if (bsel_reg == 2'd3)
                    begin
                        rnd_reg <= (rnd_reg == 7'd15) ? 7'd0 : rnd_reg + 7'd1;
                    end
                    for (int i = 0; i < 8; i++)
                        wk_reg[i] <= hash_reg[i];
                end
                ST_ROUND:
                begin
                    if (rnd_reg == 7'd0)
                    begin
                        sched_reg[15] <= {wload_reg[23:0], rd_reg};
                    end
                    if (rnd_reg >= 7'd16)
                        sched_reg[rnd_reg[3:0]] <= w_cur;
                    wk_reg[7] <= wk_reg[6];
                    wk_reg[6] <= wk_reg[5];
                    wk_reg[5] <= wk_reg[4];
                    wk_reg[4] <= wk_reg[3] + t1;
                    wk_reg[3] <= wk_reg[2];
                    wk_reg[2] <= wk_reg[1];
                    wk_reg[1] <= wk_reg[0];
                    wk_reg[0] <= t1 + t2;
                    rnd_reg <= rnd_reg + 7'd1;
                end
                ST_FOLD:
                begin
                    for (int i = 0; i < 8; i++)
                        hash_reg[i] <= hash_reg[i] + wk_reg[i];
                    rnd_reg  <= '0;
                    fill_reg <= '0;
                    two_reg  <= 1'b0;
                    if (!mark_reg && !two_reg && fin_reg)
                        widx_reg <= '0;
                end
                ST_EMIT:
                begin
                    if (out_xfer)
                    begin
                        widx_reg <= widx_reg + 3'd1;
                        if (widx_reg == 3'd7)
                        begin
                            for (int i = 0; i < 8; i++)
                                hash_reg[i] <= InitHash[i];
                            len_reg <= '0;
                            fin_reg <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // a last byte that fills the block: compress first, then pad with the mark at 0

    property p_stall_busy;
        @(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall;
    endproperty
    a_stall_busy: assert property (p_stall_busy) else $error("accepted while busy");

    a_emit_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_xfer && widx_reg != 3'd7) |=> (state_reg == ST_EMIT))
        else $error("digest cut short");

    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> (rnd_reg < 7'd64))
        else $error("round count overrun");

    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(widx_reg))
        else $error("word index moved under stall");

endmodule

// File: tb/tb_sha256_stream_hash_top.sv
`timescale 1ns / 1ps

module tb_sha256_stream_hash_top;
    import sha256_pkg::*;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_item_t;

    class digest_scoreboard;
        logic [31:0]  hash_st [8];
        logic [7:0]   block_buf [64];
        int           fill;
        logic [63:0]  msg_bits;
        digest_item_t pending_words [$];
        int           errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            for (int i = 0; i < 8; i++) hash_st[i] = InitHash[i];
            fill = 0;
            msg_bits = '0;
        endfunction

        function logic [31:0] rotr(logic [31:0] x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void fold_block();
            logic [31:0] w [64];
            logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
            for (int r = 0; r < 64; r++) begin
                if (r < 16)
                    w[r] = {block_buf[4*r], block_buf[4*r+1], block_buf[4*r+2],
                            block_buf[4*r+3]};
                else
                    w[r] = w[r-16] + (rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3))
                         + w[r-7] + (rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10));
            end
            a = hash_st[0]; b = hash_st[1]; c = hash_st[2]; d = hash_st[3];
            e = hash_st[4]; f = hash_st[5]; g = hash_st[6]; h = hash_st[7];
            for (int r = 0; r < 64; r++) begin
                t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
                   + RoundK[r] + w[r];
                t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
                h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
            end
            hash_st[0] += a; hash_st[1] += b; hash_st[2] += c; hash_st[3] += d;
            hash_st[4] += e; hash_st[5] += f; hash_st[6] += g; hash_st[7] += h;
        endfunction

        function void note_byte(logic [7:0] data, logic valid, logic last);
            if (valid) begin
                block_buf[fill] = data;
                msg_bits += 64'd8;
                fill = (fill + 1) % 64;
                if (fill == 0) fold_block();
            end
            if (!last) return;
            block_buf[fill] = PadMark;
            fill++;
            if (fill > LenPos) begin
                for (int j = fill; j < BlockLen; j++) block_buf[j] = '0;
                fold_block();
                fill = 0;
            end
            for (int j = fill; j < LenPos; j++) block_buf[j] = '0;
            for (int j = 0; j < 8; j++) block_buf[LenPos+j] = msg_bits[63-8*j -: 8];
            fold_block();
            for (int j = 0; j < 8; j++)
                pending_words.push_back('{hash_st[j], 3'(j), j == 7});
            restart();
        endfunction

        function void check_word(logic [31:0] word, logic [2:0] index, logic last);
            digest_item_t exp_w;
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected digest word %h idx %0d", $time, word, index);
                errors++;
                return;
            end
            exp_w = pending_words.pop_front();
            if (word !== exp_w.word || index !== exp_w.index || last !== exp_w.last) begin
                $display("%0t: digest mismatch expected %h/%0d/%0b actual %h/%0d/%0b",
                         $time, exp_w.word, exp_w.index, exp_w.last, word, index, last);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = '0;
    logic        byte_valid = 1'b0;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    digest_scoreboard sb = new();
    int idle_cycles = 0;
    int stall_mode = 0;

    sha256_stream_hash_top i_dut (.*);

    always #5 clk = ~clk;

    always @(posedge clk) begin
        if (rst_n && in_valid && !in_stall) sb.note_byte(data_byte, byte_valid, last_byte);
        if (rst_n && out_valid && !out_stall) sb.check_word(digest_word, word_index, last_word);
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles > 20000) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver stall pattern: phases of none, heavy, and random
    always @(negedge clk) begin
        if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= 1'($urandom_range(0, 1));
        endcase
    end

    task automatic send_byte(logic [7:0] d, logic v, logic l);
        @(negedge clk);
        in_valid <= 1'b1;
        data_byte <= d;
        byte_valid <= v;
        last_byte <= l;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send_gap();
        int n;
        n = $urandom_range(1, 6);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic send_message(int len, bit empty_close);
        int burst;
        burst = $urandom_range(1, 20);
        for (int i = 0; i < len; i++) begin
            if (burst == 0) begin
                send_gap();
                burst = $urandom_range(1, 20);
            end
            burst--;
            if ($urandom_range(0, 15) == 0) send_byte(8'($urandom), 1'b0, 1'b0);
            if (!empty_close && i == len - 1) send_byte(8'($urandom), 1'b1, 1'b1);
            else send_byte(8'($urandom), 1'b1, 1'b0);
        end
        if (empty_close || len == 0) send_byte(8'($urandom), 1'b0, 1'b1);
    endtask

    initial begin
        int sent;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hff, 1'b0, 1'b1);
        send_byte(8'h00, 1'b1, 1'b1);
        send_byte(8'hff, 1'b1, 1'b1);
        send_message(55, 1'b0);
        send_message(56, 1'b1);
        send_message(63, 1'b1);
        send_message(64, 1'b1);
        send_message(64, 1'b0);
        sent = 0;
        while (sent < 200) begin
            int len;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 130) : $urandom_range(0, 20);
            send_message(len, 1'($urandom_range(0, 1)));
            sent += len + 1;
        end
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending_words.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
